/* sv/bfbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfbp_pkg
// Field widths and status codes shared by the best-fit bin packer.
// ----------------------------------------------------------------------------
package bfbp_pkg;

  localparam int WEIGHT_W    = 16;
  localparam int CAP_W       = 16;
  localparam int BIN_INDEX_W = 8;
  localparam int FREE_W      = 16;
  localparam int BINS_USED_W = 9;
  localparam int STATUS_W    = 2;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_PLACED    = 2'd0;
  localparam status_t STATUS_TOO_HEAVY = 2'd1;
  localparam status_t STATUS_FULL      = 2'd2;

endpackage
`default_nettype wire

/* sv/best_fit_bin_packer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_bin_packer
// Places each object in the open bin with the tightest fit, or opens a new one if room remains.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                         Contents
// in_       in   in_tvalid/tready/tdata/tuser    weight; tuser = first_of_set
// out_      out  out_tvalid/tready/tdata/tuser   placement result; tuser = status
// cfg_      in   cfg_wr_en/cfg_wr_data           bin_capacity
//
// Each request is checked against the open bins by a scan that reads the
// free-space memory one bin per cycle; the chosen bin is then written and the
// result registered for output, after which the next request is taken.
// A request heavier than the capacity skips the scan and the placement.
// Reset is synchronous and active low; the memory needs no clearing pass.
// A new request is taken while the previous result waits; it then waits itself.
module best_fit_bin_packer #(
  parameter int MAX_BINS    = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [bfbp_pkg::IN_TDATA_W-1:0]   in_tdata,   // [15:0] weight
  input  wire                              in_tuser,   // [0] first_of_set
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [7:0] bin_index, [8] opened_new, [24:9] free_after, [33:25] bins_used,
  // [39:34] zero
  output logic [bfbp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [bfbp_pkg::STATUS_W-1:0]    out_tuser,  // [1:0] status
  input  wire                              cfg_wr_en,
  input  wire [bfbp_pkg::CAP_W-1:0]        cfg_wr_data
);
  import bfbp_pkg::*;

  localparam int CW = $clog2(MAX_BINS + 1);
  localparam int IW = $clog2(MAX_BINS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_PLACE = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [WEIGHT_BITS-1:0] mem [MAX_BINS];
  logic [WEIGHT_BITS-1:0] mem_q_r;
  logic                   mem_re;
  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  logic [WEIGHT_BITS-1:0] mem_wdata;

  logic [1:0]             state_r, state_nxt;
  logic [CAP_W-1:0]       capacity_r, capacity_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          addr_r, addr_nxt;
  logic                   pend_r, pend_nxt;
  logic [IW-1:0]          pend_idx_r, pend_idx_nxt;
  logic                   found_r, found_nxt;
  logic [WEIGHT_BITS-1:0] best_r, best_nxt;
  logic [IW-1:0]          best_idx_r, best_idx_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [IW-1:0]          res_idx_r, res_idx_nxt;
  logic                   res_open_r, res_open_nxt;
  logic [WEIGHT_BITS-1:0] res_free_r, res_free_nxt;
  status_t                res_status_r, res_status_nxt;

  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  status_t                out_status_r, out_status_nxt;

  logic [WEIGHT_BITS-1:0] w_in;
  logic [WEIGHT_BITS-1:0] cap;
  logic                   in_acc;
  logic                   out_load;

  assign w_in   = WEIGHT_BITS'(in_tdata[WEIGHT_W-1:0]);
  assign cap    = WEIGHT_BITS'(capacity_r);
  assign in_acc = in_tvalid && in_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    capacity_nxt   = capacity_r;
    count_nxt      = count_r;
    addr_nxt       = addr_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = addr_r[IW-1:0];
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    w_nxt          = w_r;
    out_valid_nxt  = out_valid_r;
    res_idx_nxt    = res_idx_r;
    res_open_nxt   = res_open_r;
    res_free_nxt   = res_free_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = best_idx_r;
    mem_wdata      = best_r - w_r;
    out_load       = 1'b0;

    if (cfg_wr_en) begin
      capacity_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          w_nxt          = w_in;
          addr_nxt       = '0;
          found_nxt      = 1'b0;
          res_idx_nxt    = '0;
          res_open_nxt   = 1'b0;
          res_free_nxt   = '0;
          res_status_nxt = STATUS_PLACED;
          if (in_tuser) begin
            count_nxt = '0;
          end
          if (w_in > cap) begin
            res_status_nxt = STATUS_TOO_HEAVY;
            state_nxt      = ST_FIN;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (addr_r < count_r) begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          addr_nxt = addr_r + CW'(1);
        end else if (!pend_r) begin
          state_nxt = ST_PLACE;
        end
        if (pend_r && (mem_q_r >= w_r) && (!found_r || (mem_q_r < best_r))) begin
          found_nxt    = 1'b1;
          best_nxt     = mem_q_r;
          best_idx_nxt = pend_idx_r;
        end
      end
      ST_PLACE: begin
        if (found_r) begin
          mem_we       = 1'b1;
          res_idx_nxt  = best_idx_r;
          res_free_nxt = best_r - w_r;
        end else if (count_r < CW'(MAX_BINS)) begin
          mem_we       = 1'b1;
          mem_waddr    = count_r[IW-1:0];
          mem_wdata    = cap - w_r;
          res_idx_nxt  = count_r[IW-1:0];
          res_open_nxt = 1'b1;
          res_free_nxt = cap - w_r;
          count_nxt    = count_r + CW'(1);
        end else begin
          res_status_nxt = STATUS_FULL;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_data_nxt = {6'd0, BINS_USED_W'(count_r), FREE_W'(res_free_r), res_open_r,
                      BIN_INDEX_W'(res_idx_r)};
      out_status_nxt = res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      capacity_r  <= '1;
      count_r     <= '0;
      addr_r      <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      capacity_r  <= capacity_nxt;
      count_r     <= count_nxt;
      addr_r      <= addr_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    w_r          <= w_nxt;
    res_idx_r    <= res_idx_nxt;
    res_open_r   <= res_open_nxt;
    res_free_r   <= res_free_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[addr_r[IW-1:0]];
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BINS))
    else $error("Open bin count exceeds the table size.");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (addr_r <= count_r))
    else $error("Scan address ran past the open bins.");

  a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PLACE && found_r) |-> (best_r >= w_r))
    else $error("Chosen bin cannot hold the object.");

  a_new_bin_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PLACE && !found_r && count_r < CW'(MAX_BINS)) |=>
      (count_r == $past(count_r) + CW'(1)))
    else $error("Opening a bin did not raise the bin count.");
`endif

endmodule
`default_nettype wire
